// ===== rtl/core/dtf_pkg.sv =====
// ----------------------------------------------------------------------------
// dtf_pkg
// shared constants, types and tables for the decimal text to fixed converter
// ----------------------------------------------------------------------------
package dtf_pkg;

  // number format
  localparam int FRAC_DIGITS = 4;
  localparam int VALUE_BITS  = 48;

  // magnitude holds up to the saturation cap 2^(VALUE_BITS-1)
  localparam int MAG_W = VALUE_BITS;

  localparam longint unsigned LIM_U      = (64'd1 << (VALUE_BITS - 1)) - 64'd1;
  localparam longint unsigned SCALE_FULL = 64'd10 ** FRAC_DIGITS;
  localparam longint unsigned SCALE_HUND = 64'd10 ** (FRAC_DIGITS - 2);

  localparam int SCALE_W = $clog2(SCALE_FULL + 1);
  localparam int FRAC_W  = $clog2(SCALE_FULL);
  localparam int CNT_W   = $clog2(FRAC_DIGITS + 1);
  localparam int IDX_W   = $clog2(FRAC_DIGITS);
  localparam int SUM_W   = ((MAG_W > FRAC_W) ? MAG_W : FRAC_W) + 1;
  localparam int HALF_W  = MAG_W / 2;
  localparam int HI_W    = MAG_W - HALF_W;

  localparam logic [MAG_W-1:0] MAG_LIM = {1'b0, {(MAG_W-1){1'b1}}};
  localparam logic [MAG_W-1:0] MAG_CAP = {1'b1, {(MAG_W-1){1'b0}}};
  localparam logic [MAG_W-1:0] LIM_DIV_FULL = MAG_W'(LIM_U / SCALE_FULL);
  localparam logic [MAG_W-1:0] LIM_DIV_HUND = MAG_W'(LIM_U / SCALE_HUND);
  localparam logic signed [VALUE_BITS-1:0] VALUE_LIM = $signed(MAG_LIM);

  localparam logic [SCALE_W-1:0] SCALE_FULL_V = SCALE_W'(SCALE_FULL);
  localparam logic [SCALE_W-1:0] SCALE_HUND_V = SCALE_W'(SCALE_HUND);

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQUAL = 8'h3d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_INT,
    PH_FRAC,
    PH_TRAIL,
    PH_BAD
  } dtf_phase_t;

  // one finished text, handed from front to back
  typedef struct packed {
    logic              ok;
    logic              negative;
    logic              hund;
    logic [MAG_W-1:0]  magnitude;
    logic [FRAC_W-1:0] frac;
  } dtf_job_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } dtf_q_stat_t;

  // weight of each fraction digit position, most significant first
  typedef logic [FRAC_W-1:0] dtf_weight_arr_t [FRAC_DIGITS];

  function automatic dtf_weight_arr_t make_frac_weights();
    dtf_weight_arr_t w;
    longint unsigned p;
    p = 64'd1;
    for (int i = FRAC_DIGITS - 1; i >= 0; i--) begin
      w[i] = FRAC_W'(p);
      p = p * 64'd10;
    end
    return w;
  endfunction

  localparam dtf_weight_arr_t FRAC_WEIGHT = make_frac_weights();

endpackage

// ===== rtl/core/dtf_in_if.sv =====
// ----------------------------------------------------------------------------
// dtf_in_if
// character item channel: valid, ready and one character with end marker
// ----------------------------------------------------------------------------
interface dtf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

// ===== rtl/core/dtf_out_if.sv =====
// ----------------------------------------------------------------------------
// dtf_out_if
// result item channel: valid, ready and the converted value with flags
// ----------------------------------------------------------------------------
interface dtf_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   valid_res;
  logic signed [dtf_pkg::VALUE_BITS-1:0]  value;
  logic                                   saturated;

  modport source (output valid, output valid_res, output value, output saturated,
                  input ready);
  modport sink   (input valid, input valid_res, input value, input saturated,
                  output ready);
endinterface

// ===== rtl/core/dtf_front.sv =====
// ----------------------------------------------------------------------------
// dtf_front
// character parser: grammar state machine, digit accumulation, job push
// ----------------------------------------------------------------------------
module dtf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  dtf_in_if.sink               in_if,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  dtf_pkg::dtf_q_stat_t q_stat,
  output logic                 push,
  output dtf_pkg::dtf_job_t    push_job
);
  import dtf_pkg::*;

  dtf_phase_t        phase_r, phase_nxt;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic              seen_dig_r, seen_dig_nxt;
  logic              seen_dot_r, seen_dot_nxt;
  logic              hund_r;

  logic              accept;
  logic              is_sep, is_dig;
  logic [3:0]        dig;
  logic [MAG_W+3:0]  mag_wide, mag_x10;
  logic [MAG_W-1:0]  mag_added;
  logic [FRAC_W-1:0] frac_added;

  assign in_if.ready = !q_stat.full;
  assign accept      = in_if.valid && in_if.ready;

  assign is_sep = in_if.ch inside {CH_SPACE, CH_EQUAL, CH_COLON};
  assign is_dig = in_if.ch inside {[CH_ZERO:CH_NINE]};
  assign dig    = in_if.ch[3:0];

  // saturating magnitude * 10 + digit
  assign mag_wide  = {4'b0, mag_r};
  assign mag_x10   = (mag_wide << 3) + (mag_wide << 1) + {{MAG_W{1'b0}}, dig};
  assign mag_added = (mag_x10 > {4'b0, MAG_CAP}) ? MAG_CAP : mag_x10[MAG_W-1:0];

  assign frac_added = frac_r
                    + FRAC_W'({{(FRAC_W-4){1'b0}}, dig} * FRAC_WEIGHT[cnt_r[IDX_W-1:0]]);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (in_if.end_of_text) begin
        phase_nxt = PH_LEAD;
      end else begin
        case (phase_r)
          PH_LEAD: begin
            if (is_sep) phase_nxt = PH_LEAD;
            else if (in_if.ch == CH_MINUS || in_if.ch == CH_PLUS) phase_nxt = PH_SIGN;
            else if (is_dig) phase_nxt = PH_INT;
            else if (in_if.ch == CH_DOT) phase_nxt = PH_FRAC;
            else phase_nxt = PH_BAD;
          end
          PH_SIGN, PH_INT: begin
            if (is_dig) phase_nxt = PH_INT;
            else if (in_if.ch == CH_DOT) phase_nxt = PH_FRAC;
            else if (is_sep) phase_nxt = PH_TRAIL;
            else phase_nxt = PH_BAD;
          end
          PH_FRAC: begin
            if (is_dig) phase_nxt = PH_FRAC;
            else if (is_sep) phase_nxt = PH_TRAIL;
            else phase_nxt = PH_BAD;
          end
          PH_TRAIL: begin
            if (!is_sep) phase_nxt = PH_BAD;
          end
          default: phase_nxt = PH_BAD;
        endcase
      end
    end
  end

  // datapath updates
  always_comb begin
    mag_nxt      = mag_r;
    frac_nxt     = frac_r;
    cnt_nxt      = cnt_r;
    neg_nxt      = neg_r;
    seen_dig_nxt = seen_dig_r;
    seen_dot_nxt = seen_dot_r;
    if (accept) begin
      if (in_if.end_of_text) begin
        mag_nxt      = '0;
        frac_nxt     = '0;
        cnt_nxt      = '0;
        neg_nxt      = 1'b0;
        seen_dig_nxt = 1'b0;
        seen_dot_nxt = 1'b0;
      end else begin
        case (phase_r)
          PH_LEAD, PH_SIGN, PH_INT: begin
            if (phase_r == PH_LEAD && in_if.ch == CH_MINUS) begin
              neg_nxt = 1'b1;
            end else if (is_dig && !(phase_r == PH_LEAD && is_sep)) begin
              mag_nxt      = mag_added;
              seen_dig_nxt = 1'b1;
            end else if (in_if.ch == CH_DOT) begin
              seen_dot_nxt = 1'b1;
            end
          end
          PH_FRAC: begin
            if (is_dig) begin
              seen_dig_nxt = 1'b1;
              if (cnt_r < CNT_W'(FRAC_DIGITS)) begin
                cnt_nxt  = cnt_r + CNT_W'(1);
                frac_nxt = frac_added;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LEAD;
      mag_r      <= '0;
      frac_r     <= '0;
      cnt_r      <= '0;
      neg_r      <= 1'b0;
      seen_dig_r <= 1'b0;
      seen_dot_r <= 1'b0;
      hund_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      mag_r      <= mag_nxt;
      frac_r     <= frac_nxt;
      cnt_r      <= cnt_nxt;
      neg_r      <= neg_nxt;
      seen_dig_r <= seen_dig_nxt;
      seen_dot_r <= seen_dot_nxt;
      if (cfg_we) hund_r <= cfg_wdata;
    end
  end

  assign push               = accept && in_if.end_of_text;
  assign push_job.ok        = (phase_r != PH_BAD) && seen_dig_r;
  assign push_job.negative  = neg_r;
  assign push_job.hund      = hund_r && !seen_dot_r;
  assign push_job.magnitude = mag_r;
  assign push_job.frac      = frac_r;

endmodule

// ===== rtl/core/dtf_queue.sv =====
// ----------------------------------------------------------------------------
// dtf_queue
// short job queue between parser and arithmetic back end
// ----------------------------------------------------------------------------
module dtf_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  dtf_pkg::dtf_job_t    push_job,
  input  logic                 pop,
  output dtf_pkg::dtf_job_t    pop_job,
  output dtf_pkg::dtf_q_stat_t stat
);
  import dtf_pkg::*;

  dtf_job_t          entry_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign stat.full      = (count_r == QCNT_W'(Q_DEPTH));
  assign stat.not_empty = (count_r != '0);
  assign pop_job        = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/dtf_back.sv =====
// ----------------------------------------------------------------------------
// dtf_back
// scaling pipeline: partial products, sum with fraction, clamp and sign
// ----------------------------------------------------------------------------
module dtf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dtf_pkg::dtf_q_stat_t q_stat,
  input  dtf_pkg::dtf_job_t    pop_job,
  output logic                 pop,
  dtf_out_if.source            out_if
);
  import dtf_pkg::*;

  logic                     en;
  logic [SCALE_W-1:0]       scale;
  logic [MAG_W-1:0]         lim_div;

  // stage 1
  logic                     s1_v_r;
  logic                     s1_ok_r, s1_neg_r, s1_over_r;
  logic [HALF_W+SCALE_W-1:0] s1_pp_lo_r, s1_pp_lo_nxt;
  logic [HI_W+SCALE_W-1:0]  s1_pp_hi_r, s1_pp_hi_nxt;
  logic [FRAC_W-1:0]        s1_frac_r;

  // stage 2
  logic                     s2_v_r;
  logic                     s2_ok_r, s2_neg_r, s2_over_r;
  logic [SUM_W-1:0]         s2_sum_r, s2_sum_nxt;

  // output register
  logic                     out_v_r;
  logic                     out_ok_r, out_sat_r;
  logic [MAG_W-1:0]         out_val_r;
  logic                     clamp;
  logic [MAG_W-1:0]         mag_fin, val_fin;

  assign en  = !out_v_r || out_if.ready;
  assign pop = en && q_stat.not_empty;

  assign scale   = pop_job.hund ? SCALE_HUND_V : SCALE_FULL_V;
  assign lim_div = pop_job.hund ? LIM_DIV_HUND : LIM_DIV_FULL;

  assign s1_pp_lo_nxt = (HALF_W+SCALE_W)'(pop_job.magnitude[HALF_W-1:0])
                      * (HALF_W+SCALE_W)'(scale);
  assign s1_pp_hi_nxt = (HI_W+SCALE_W)'(pop_job.magnitude[MAG_W-1:HALF_W])
                      * (HI_W+SCALE_W)'(scale);

  assign s2_sum_nxt = SUM_W'({s1_pp_hi_r, {HALF_W{1'b0}}})
                    + SUM_W'(s1_pp_lo_r)
                    + SUM_W'(s1_frac_r);

  assign clamp   = s2_over_r || (s2_sum_r > SUM_W'(MAG_LIM));
  assign mag_fin = clamp ? MAG_LIM : s2_sum_r[MAG_W-1:0];
  assign val_fin = s2_neg_r ? (~mag_fin + MAG_W'(1)) : mag_fin;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ok_r    <= pop_job.ok;
      s1_neg_r   <= pop_job.negative;
      s1_over_r  <= pop_job.magnitude > lim_div;
      s1_pp_lo_r <= s1_pp_lo_nxt;
      s1_pp_hi_r <= s1_pp_hi_nxt;
      s1_frac_r  <= pop_job.frac;
      s2_ok_r    <= s1_ok_r;
      s2_neg_r   <= s1_neg_r;
      s2_over_r  <= s1_over_r;
      s2_sum_r   <= s2_sum_nxt;
      out_ok_r   <= s2_ok_r;
      out_sat_r  <= s2_ok_r && clamp;
      out_val_r  <= s2_ok_r ? val_fin : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= q_stat.not_empty;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  assign out_if.valid     = out_v_r;
  assign out_if.valid_res = out_ok_r;
  assign out_if.value     = $signed(out_val_r);
  assign out_if.saturated = out_sat_r;

endmodule

// ===== rtl/core/decimal_text_to_fixed.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_fixed
// converts decimal number text, one character item at a time, to signed
// fixed point in units of 10^-FRAC_DIGITS
// ----------------------------------------------------------------------------
//
//  channel | direction | payload                          | handshake
//  --------+-----------+----------------------------------+------------------
//  in_if   | sink      | ch[7:0], end_of_text             | valid / ready
//  out_if  | source    | valid_res, value[47:0], saturated| valid / ready
//  cfg     | write     | cfg_wdata = hundredths_mode      | cfg_we, no wait
//
//  one character item per cycle while the job queue has room; an end item's
//  result passes the queue, product stage, sum stage and output register
//  rst_n is synchronous; it clears the parser state, the queue and the
//  pipeline valids, and no clearing pass follows
//  in_if.ready drops only while the two-entry job queue is full; the back end
//  pipeline holds as a whole while a result waits on out_if.ready
// ----------------------------------------------------------------------------
module decimal_text_to_fixed (
  input  logic       clk,
  input  logic       rst_n,
  dtf_in_if.sink     in_if,
  dtf_out_if.source  out_if,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);
  import dtf_pkg::*;

  // job handoff between parser and arithmetic
  logic        push;
  logic        pop;
  dtf_job_t    push_job;
  dtf_job_t    pop_job;
  dtf_q_stat_t q_stat;

  // front: grammar state machine and digit accumulation
  dtf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  // short queue so a stalled result does not stop character intake at once
  dtf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  // back: scale by a power of ten, add fraction, clamp, apply sign
  dtf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .pop_job (pop_job),
    .pop     (pop),
    .out_if  (out_if)
  );

  // an invalid text always reports zero and no saturation
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.valid_res |-> out_if.value == '0 && !out_if.saturated)
    else $error("invalid result carries a nonzero value or flag");

  // a saturated result sits on one of the two symmetric limits
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.saturated |->
      (out_if.value == VALUE_LIM || out_if.value == -VALUE_LIM))
    else $error("saturated result is not at the clamp limit");

  // the queue is never written while full
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("job pushed into a full queue");

  // a pop only happens with something queued
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.not_empty)
    else $error("job popped from an empty queue");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for decimal_text_to_fixed: streams character items
// (directed texts, then random numbers, broken texts and noise) through the
// input channel, predicts each end item's fixed-point result in a local model
// and compares it field by field with what leaves the result channel
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dtf_pkg::*;

  // cycles the receiver holds off during the pressure phase
  localparam int LONG_HOLD     = 400;
  // cycles with no accepted item before the run is declared hung
  localparam int IDLE_LIMIT    = 3000;
  // quiet cycles after the last result before a register write or the end
  localparam int SETTLE_CYCLES = 8;
  // input items per random phase
  localparam int PHASE_ITEMS   = 300;
  localparam int RANDOM_PHASES = 6;

  // one character item as it goes onto the input channel
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } char_item_t;

  // one predicted conversion
  typedef struct packed {
    logic                         ok;
    logic signed [VALUE_BITS-1:0] value;
    logic                         sat;
  } fixed_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  dtf_in_if  char_if ();
  dtf_out_if fix_if ();

  decimal_text_to_fixed u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (char_if),
    .out_if    (fix_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // items waiting to be offered, filled by the stimulus process
  char_item_t    char_queue[$];
  // conversions predicted but not yet seen on the result channel
  fixed_result_t expected_fixed[$];

  int  queued_items = 0;
  int  error_count  = 0;
  // gaps on both channels are switched off for one phase
  bit  gaps_on      = 1'b1;
  // bumped by the stimulus to ask the receiver for one long hold
  int  stall_req    = 0;
  // hundredths mode as last written into the block
  bit  hund_mode    = 1'b0;

  // local copy of the parser state
  dtf_phase_t      text_phase = PH_LEAD;
  longint unsigned int_part   = 0;
  longint unsigned frac_part  = 0;
  int              frac_count = 0;
  bit              text_neg   = 1'b0;
  bit              text_digit = 1'b0;
  bit              text_dot   = 1'b0;

  task automatic report_error(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // most gaps short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic bit is_sep(input logic [7:0] c);
    return c == CH_SPACE || c == CH_EQUAL || c == CH_COLON;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic longint unsigned pow_ten(input int n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  // integer digit, sticking at 2^(VALUE_BITS-1) once too large
  function automatic void add_int_digit(input longint unsigned d);
    longint unsigned cap;
    cap = LIM_U + 1;
    if (int_part > (cap - d) / 10) int_part = cap;
    else int_part = int_part * 10 + d;
    text_digit = 1'b1;
  endfunction

  // fraction digit; digits past the precision only count as digits
  function automatic void add_frac_digit(input longint unsigned d);
    if (frac_count < FRAC_DIGITS) begin
      frac_count++;
      frac_part += d * pow_ten(FRAC_DIGITS - frac_count);
    end
    text_digit = 1'b1;
  endfunction

  // advances the local parser by one accepted item; an end item closes the
  // text, queues its predicted conversion and clears the state
  function automatic void parse_char(input logic [7:0] c, input logic eot);
    fixed_result_t   res;
    longint unsigned scale;
    longint unsigned mag;
    bit              ok;
    bit              sat;
    if (!eot) begin
      case (text_phase)
        PH_LEAD: begin
          if (is_sep(c)) begin
          end else if (c == CH_MINUS) begin
            text_neg   = 1'b1;
            text_phase = PH_SIGN;
          end else if (c == CH_PLUS) begin
            text_phase = PH_SIGN;
          end else if (is_digit(c)) begin
            add_int_digit(64'(c - CH_ZERO));
            text_phase = PH_INT;
          end else if (c == CH_DOT) begin
            text_dot   = 1'b1;
            text_phase = PH_FRAC;
          end else begin
            text_phase = PH_BAD;
          end
        end
        PH_SIGN, PH_INT: begin
          if (is_digit(c)) begin
            add_int_digit(64'(c - CH_ZERO));
            text_phase = PH_INT;
          end else if (c == CH_DOT) begin
            text_dot   = 1'b1;
            text_phase = PH_FRAC;
          end else if (is_sep(c)) begin
            text_phase = PH_TRAIL;
          end else begin
            text_phase = PH_BAD;
          end
        end
        PH_FRAC: begin
          if (is_digit(c)) add_frac_digit(64'(c - CH_ZERO));
          else if (is_sep(c)) text_phase = PH_TRAIL;
          else text_phase = PH_BAD;
        end
        PH_TRAIL: begin
          if (!is_sep(c)) text_phase = PH_BAD;
        end
        default: text_phase = PH_BAD;
      endcase
      return;
    end
    ok  = (text_phase != PH_BAD) && text_digit;
    sat = 1'b0;
    mag = 0;
    if (ok) begin
      // hundredths mode only applies to a text without a dot
      scale = (hund_mode && !text_dot) ? pow_ten(FRAC_DIGITS - 2) : pow_ten(FRAC_DIGITS);
      if (int_part > LIM_U / scale) begin
        sat = 1'b1;
        mag = LIM_U;
      end else begin
        mag = int_part * scale;
        if (frac_part > LIM_U - mag) begin
          sat = 1'b1;
          mag = LIM_U;
        end else begin
          mag += frac_part;
        end
      end
      // symmetric clamp, and minus zero stays zero
      if (text_neg) mag = -mag;
    end
    res.ok    = ok;
    res.value = ok ? mag[VALUE_BITS-1:0] : '0;
    res.sat   = ok && sat;
    expected_fixed.push_back(res);
    text_phase = PH_LEAD;
    int_part   = 0;
    frac_part  = 0;
    frac_count = 0;
    text_neg   = 1'b0;
    text_digit = 1'b0;
    text_dot   = 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // driver: offers queued items, holds each until ready, idles at random
  // --------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    char_item_t next_item;
    if (!rst_n) begin
      char_if.valid <= 1'b0;
    end else begin
      // item on the channel is taken at this edge
      if (char_if.valid && char_if.ready)
        parse_char(char_if.ch, char_if.end_of_text);
      // channel free for a new item, or idle
      if (!char_if.valid || char_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          char_if.valid <= 1'b0;
        end else if (char_queue.size() > 0) begin
          next_item = char_queue.pop_front();
          char_if.valid       <= 1'b1;
          char_if.ch          <= next_item.ch;
          char_if.end_of_text <= next_item.eot;
          send_gap = pick_gap();
        end else begin
          char_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks each accepted result against the oldest prediction and
  // drives ready with random gaps and, on request, one long hold
  // --------------------------------------------------------------------------
  int recv_gap   = 0;
  int stall_seen = 0;

  always @(posedge clk) begin
    fixed_result_t want;
    if (!rst_n) begin
      fix_if.ready <= 1'b0;
    end else begin
      if (fix_if.valid && fix_if.ready) begin
        if (expected_fixed.size() == 0) begin
          report_error($sformatf("result with none pending: valid_res %0b value %0d",
                                 fix_if.valid_res, fix_if.value));
        end else begin
          want = expected_fixed.pop_front();
          if (fix_if.valid_res !== want.ok)
            report_error($sformatf("valid_res %0b, predicted %0b",
                                   fix_if.valid_res, want.ok));
          if (fix_if.value !== want.value)
            report_error($sformatf("value %0d, predicted %0d", fix_if.value, want.value));
          if (fix_if.saturated !== want.sat)
            report_error($sformatf("saturated %0b, predicted %0b",
                                   fix_if.saturated, want.sat));
        end
      end
      // long hold, counted here while the sender keeps offering
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        recv_gap   = LONG_HOLD;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        fix_if.ready <= 1'b0;
      end else begin
        fix_if.ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: ends the run when no item moves on either channel for too long
  // --------------------------------------------------------------------------
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((char_if.valid && char_if.ready) || (fix_if.valid && fix_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("testbench: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_char(input logic [7:0] c, input logic eot);
    char_queue.push_back('{ch: c, eot: eot});
    queued_items++;
  endtask

  // whole text followed by its end item; the end item's character is junk
  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0);
    push_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] rand_sep();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_EQUAL;
      default: return CH_COLON;
    endcase
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // mostly well-formed numbers with random content, some with one stray
  // character put in, some pure noise
  task automatic gen_text();
    logic [7:0] body[$];
    int         r;
    int         n;
    int         pos;
    logic [7:0] stray;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      n = $urandom_range(0, 6);
      repeat (n) body.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) body.push_back(rand_sep());
      case ($urandom_range(0, 3))
        0:       body.push_back(CH_MINUS);
        1:       body.push_back(CH_PLUS);
        default: ;
      endcase
      // most integer parts short, a few long enough to saturate
      n = $urandom_range(0, 99);
      if (n < 65) n = $urandom_range(0, 4);
      else if (n < 90) n = $urandom_range(5, 10);
      else n = $urandom_range(11, 20);
      repeat (n) body.push_back(rand_digit());
      if ($urandom_range(0, 1)) begin
        body.push_back(CH_DOT);
        repeat ($urandom_range(0, 7)) body.push_back(rand_digit());
      end
      repeat ($urandom_range(0, 2)) body.push_back(rand_sep());
      if (r < 30) begin
        case ($urandom_range(0, 4))
          0:       stray = CH_MINUS;
          1:       stray = CH_PLUS;
          2:       stray = CH_DOT;
          3:       stray = CH_SPACE;
          default: stray = 8'($urandom_range(0, 255));
        endcase
        pos = $urandom_range(0, body.size());
        body.insert(pos, stray);
      end
    end
    foreach (body[i]) push_char(body[i], 1'b0);
    push_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // returns once everything is sent and every result is in, plus a margin
  // for a character item still inside the block
  task automatic wait_idle();
    do @(negedge clk);
    while (char_queue.size() != 0 || char_if.valid || expected_fixed.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write at the next edge; called right after a rising edge
  task automatic write_mode(input bit v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    hund_mode = v;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase_start;
    // every input known from time zero
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = 1'b0;
    char_if.valid       = 1'b0;
    char_if.ch          = 8'h00;
    char_if.end_of_text = 1'b0;
    fix_if.ready        = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed texts, full-precision mode
    write_mode(1'b0);
    push_text("0");
    push_text("-0");
    push_text("+7");
    push_text(" =:12.5");
    push_text("1.23456");              // digits past the precision dropped
    push_text(".5");
    push_text("5.");
    push_text("");                     // no digit at all
    push_text("-");
    push_text(".");
    push_text("1-");                   // sign after digits
    push_text("+-1");                  // second sign
    push_text("1.2.3");                // second dot
    push_text("1 2");                  // digit after a trailing separator
    push_text("12: =");
    push_text("14073748835.5327");     // largest value that fits
    push_text("-14073748835.5328");    // one past it, clamped
    push_text("99999999999999999999"); // integer part sticks at the cap
    push_text("abc");
    push_char(8'h00, 1'b0);            // nul
    push_text("");
    push_char(CH_NINE, 1'b0);          // non-ascii after a digit
    push_char(8'hff, 1'b0);
    push_text("");
    wait_idle();

    // directed texts, hundredths mode
    write_mode(1'b1);
    push_text("12345");
    push_text("-1.5");                 // dot present, full precision
    push_text("1407374883553");        // fits after the multiply by 100
    push_text("-1407374883554");       // clamped
    push_text("0.01");
    wait_idle();

    // random phases; one without any idling, one with a long receiver hold
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      @(posedge clk);
      write_mode((p % 2) == 1);
      gaps_on = (p != 2);
      if (p == 3) stall_req++;
      phase_start = queued_items;
      while (queued_items - phase_start < PHASE_ITEMS) gen_text();
      wait_idle();
    end
    gaps_on = 1'b1;

    if (expected_fixed.size() != 0)
      report_error($sformatf("%0d predicted results never came", expected_fixed.size()));
    if (error_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
